// File: design/kli_pkg.sv
// Shared types, codes and channel helpers for the keyframe interpolator.
// No dependencies; used by kli_store, kli_mix and the top level of the block.
package kli_pkg;

  // Action codes of an input transfer
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  // Status codes of a result transfer
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_ZERO_SEG = 2'd3;

  localparam int NUM_CH = 8;

  // One keyframe entry, 192 bits
  typedef struct packed {
    logic signed [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [31:0]        radius;
  } frame_t;

  // Output range class of a channel
  typedef enum logic [1:0] {
    KIND_POS    = 2'd0,
    KIND_COLOR  = 2'd1,
    KIND_RADIUS = 2'd2
  } kind_t;

  // Channel value as 33-bit signed: x, y, z, r, g, b, a, radius
  function automatic logic signed [32:0] ch_value(frame_t f, logic [2:0] ch);
    logic signed [32:0] v;
    case (ch)
      3'd0:    v = {f.x[31], f.x};
      3'd1:    v = {f.y[31], f.y};
      3'd2:    v = {f.z[31], f.z};
      3'd3:    v = {25'd0, f.red};
      3'd4:    v = {25'd0, f.green};
      3'd5:    v = {25'd0, f.blue};
      3'd6:    v = {25'd0, f.alpha};
      default: v = {1'b0, f.radius};
    endcase
    return v;
  endfunction

  function automatic kind_t ch_kind(logic [2:0] ch);
    kind_t k;
    case (ch)
      3'd0, 3'd1, 3'd2:       k = KIND_POS;
      3'd3, 3'd4, 3'd5, 3'd6: k = KIND_COLOR;
      default:                k = KIND_RADIUS;
    endcase
    return k;
  endfunction

endpackage

// File: design/kli_store.sv
// Keyframe table: single write port, single read port, registered read data.
// Depends on kli_pkg for the entry type.
module kli_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  kli_pkg::frame_t   wr_data,
  input  logic [AW-1:0]     rd_addr,
  output kli_pkg::frame_t   rd_data
);

  kli_pkg::frame_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/kli_div.sv
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// No package dependencies.
module kli_div #(
  parameter int NW = 49
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [32:0]   den,
  output logic                 done,
  output logic signed [NW:0]   quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   nmag;
  logic [32:0]     dmag;
  logic [33:0]     rem;
  logic            neg;
  logic            busy;
  logic [CNTW-1:0] cnt;

  logic [33:0] rem_sh;
  logic        qbit;
  logic [NW:0] num_abs;
  logic [33:0] den_abs;

  always_comb begin
    num_abs = num[NW-1] ? -{num[NW-1], num} : {num[NW-1], num};
    den_abs = den[32] ? -{den[32], den} : {den[32], den};
    rem_sh  = {rem[32:0], nmag[NW-1]};
    qbit    = (rem_sh >= {1'b0, dmag});
  end

  // Iterate: shift in a numerator bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nmag <= num_abs[NW-1:0];
      dmag <= den_abs[32:0];
      neg  <= num[NW-1] ^ den[32];
      rem  <= '0;
    end else if (busy) begin
      rem  <= qbit ? rem_sh - {1'b0, dmag} : rem_sh;
      nmag <= {nmag[NW-2:0], qbit};
    end
  end

  assign quo = neg ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});

endmodule

// File: design/kli_mix.sv
// Six-stage pipelined channel mixer: a + (b - a) * tq, clamped, truncated, saturated.
// Depends on kli_pkg for the channel kind.
module kli_mix #(
  parameter int FRAC_BITS = 16,
  parameter int TQW       = 50
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [32:0]    a,
  input  logic signed [32:0]    b,
  input  kli_pkg::kind_t        kind,
  input  logic signed [TQW-1:0] tq,
  output logic                  res_valid,
  output logic [31:0]           result
);

  localparam int MW = TQW - 1;
  localparam int H  = (MW + 1) / 2;
  localparam int HW = MW - H;
  localparam int PW = 33 + MW;
  localparam logic [PW-1:0] LIM = PW'(1) << 61;
  localparam logic [63:0] BIAS = (64'd1 << FRAC_BITS) - 64'd1;

  logic [5:1] v;
  logic signed [32:0] a1, a2, a3, a4;
  kli_pkg::kind_t k1, k2, k3, k4, k5;
  logic signed [33:0] d1;
  logic signed [TQW-1:0] tq1;
  logic [32:0] dmag2;
  logic [MW-1:0] tmag2;
  logic neg2, neg3;
  logic [32+H:0] plo3;
  logic [32+HW:0] phi3;
  logic signed [62:0] prod4;
  logic signed [63:0] s5;

  logic [33:0] d_abs;
  logic [TQW-1:0] t_abs;
  logic [PW-1:0] full;
  logic [61:0] mag;
  logic signed [63:0] q;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      res_valid <= 1'b0;
    end else begin
      v         <= {v[4:1], in_valid};
      res_valid <= v[5];
    end
  end

  always_comb begin
    d_abs = d1[33] ? -d1 : d1;
    t_abs = tq1[TQW-1] ? -tq1 : tq1;
    full  = PW'(plo3) + (PW'(phi3) << H);
    mag   = (full > LIM) ? 62'(LIM) : full[61:0];
    q     = (s5 + (s5[63] ? $signed(BIAS) : 64'sd0)) >>> FRAC_BITS;
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    a1    <= a;
    d1    <= {b[32], b} - {a[32], a};
    k1    <= kind;
    tq1   <= tq;
    a2    <= a1;
    k2    <= k1;
    dmag2 <= d_abs[32:0];
    tmag2 <= t_abs[MW-1:0];
    neg2  <= d1[33] ^ tq1[TQW-1];
    a3    <= a2;
    k3    <= k2;
    neg3  <= neg2;
    plo3  <= dmag2 * tmag2[H-1:0];
    phi3  <= dmag2 * tmag2[MW-1:H];
    a4    <= a3;
    k4    <= k3;
    prod4 <= neg3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    k5    <= k4;
    s5    <= ($signed(64'(a4)) <<< FRAC_BITS) + 64'(prod4);
  end

  // Saturate to the channel range
  always_ff @(posedge clk) begin
    case (k5)
      kli_pkg::KIND_POS: begin
        if (q > 64'sh7FFF_FFFF) result <= 32'h7FFF_FFFF;
        else if (q < -64'sh8000_0000) result <= 32'h8000_0000;
        else result <= q[31:0];
      end
      kli_pkg::KIND_COLOR: begin
        if (q < 0) result <= 32'd0;
        else if (q > 64'sd255) result <= 32'd255;
        else result <= q[31:0];
      end
      default: begin
        if (q < 0) result <= 32'd0;
        else if (q > 64'sh FFFF_FFFF) result <= 32'hFFFF_FFFF;
        else result <= q[31:0];
      end
    endcase
  end

endmodule

// File: design/keyframe_linear_interpolator_top.sv
// Keyframe linear interpolator: keyframe table in one synchronous memory, sequencer,
// divider and mixer. Depends on kli_pkg, kli_store, kli_div and kli_mix.
//
// One transfer in gives one transfer out. Clear and append go from the accept
// cycle straight to loading the output register. A query passes through the accept
// cycle, the first table read, one memory read and compare per further table entry,
// segment setup, the bit-serial divider, the eight channels through the six-stage
// mixer and the output register. The input stalls while an item is in flight; a
// finished result waits in the output register without blocking the next input.
module keyframe_linear_interpolator_top #(
  parameter int MAX_FRAMES = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [31:0] time_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [7:0]         alpha,
  input  logic [31:0]        radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic [31:0]        out_radius,
  output logic [5:0]         segment_index
);

  localparam int AW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW  = $clog2(MAX_FRAMES + 1);
  localparam int NW  = 33 + FRAC_BITS;
  localparam int TQW = NW + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD0   = 8'b0000_0010,
    S_ISSUE = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_PREP  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_MIX   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] k;
  logic [AW-1:0] a_idx;
  logic signed [31:0] qtime;
  kli_pkg::frame_t n0, n1;
  logic signed [TQW-1:0] tq;
  logic [1:0] res_status;
  logic [5:0] res_seg;
  logic [31:0] res_val [kli_pkg::NUM_CH];
  logic [3:0] ch;
  logic [2:0] ocnt;

  logic accept;
  logic wr_en;
  kli_pkg::frame_t wr_data, rd_data;
  logic [AW-1:0] rd_addr;
  logic signed [32:0] den, diff;
  logic div_start, div_done;
  logic signed [TQW-1:0] quo;
  logic mix_valid, mix_res_valid;
  logic [31:0] mix_result;
  logic out_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // Table write on append with room
  always_comb begin
    wr_en          = accept && (action == kli_pkg::ACT_APPEND) && (count != CW'(MAX_FRAMES));
    wr_data.t      = time_value;
    wr_data.x      = pos_x;
    wr_data.y      = pos_y;
    wr_data.z      = pos_z;
    wr_data.red    = red;
    wr_data.green  = green;
    wr_data.blue   = blue;
    wr_data.alpha  = alpha;
    wr_data.radius = radius;
    rd_addr        = (state == S_ISSUE) ? k[AW-1:0] : '0;
  end

  // Segment setup for the divider
  always_comb begin
    den       = {n1.t[31], n1.t} - {n0.t[31], n0.t};
    diff      = {qtime[31], qtime} - {n0.t[31], n0.t};
    div_start = (state == S_PREP) && (den != 0);
    mix_valid = (state == S_MIX) && !ch[3];
  end

  kli_store #(.DEPTH(MAX_FRAMES), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kli_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ($signed({diff, {FRAC_BITS{1'b0}}})),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  kli_mix #(.FRAC_BITS(FRAC_BITS), .TQW(TQW)) u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .a         (kli_pkg::ch_value(n0, ch[2:0])),
    .b         (kli_pkg::ch_value(n1, ch[2:0])),
    .kind      (kli_pkg::ch_kind(ch[2:0])),
    .tq        (tq),
    .res_valid (mix_res_valid),
    .result    (mix_result)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_OUT;
            if (action == kli_pkg::ACT_CLEAR) begin
              count <= '0;
            end else if (wr_en) begin
              count <= count + 1'b1;
            end else if (action == kli_pkg::ACT_QUERY && count != '0) begin
              state <= S_RD0;
            end
          end
        end
        S_RD0:   state <= S_ISSUE;
        S_ISSUE: state <= (k >= count) ? S_OUT : S_SCAN;
        S_SCAN:  state <= (qtime < rd_data.t) ? S_PREP : S_ISSUE;
        S_PREP:  state <= (den == 0) ? S_OUT : S_DIV;
        S_DIV:   if (div_done) state <= S_MIX;
        S_MIX:   if (mix_res_valid && ocnt == 3'd7) state <= S_OUT;
        S_OUT:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers and staged result
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        qtime   <= time_value;
        k       <= CW'(1);
        a_idx   <= '0;
        res_seg <= wr_en ? 6'(count) : 6'd0;
        for (int i = 0; i < kli_pkg::NUM_CH; i++) res_val[i] <= '0;
        unique case (action)
          kli_pkg::ACT_APPEND: begin
            res_status <= wr_en ? kli_pkg::ST_OK : kli_pkg::ST_FULL;
          end
          kli_pkg::ACT_QUERY: res_status <= (count == '0) ? kli_pkg::ST_EMPTY : kli_pkg::ST_OK;
          default: res_status <= kli_pkg::ST_OK;
        endcase
      end
      S_RD0: n0 <= rd_data;
      S_ISSUE: begin
        // Past the last frame: return the start frame unchanged
        res_status <= kli_pkg::ST_OK;
        res_seg    <= 6'(a_idx);
        for (int i = 0; i < kli_pkg::NUM_CH; i++) begin
          res_val[i] <= 32'(kli_pkg::ch_value(n0, 3'(i)));
        end
      end
      S_SCAN: begin
        if (qtime < rd_data.t) begin
          n1 <= rd_data;
        end else begin
          n0    <= rd_data;
          a_idx <= k[AW-1:0];
          k     <= k + 1'b1;
        end
      end
      S_PREP: begin
        res_status <= kli_pkg::ST_ZERO_SEG;
        res_seg    <= 6'(a_idx);
        for (int i = 0; i < kli_pkg::NUM_CH; i++) begin
          res_val[i] <= 32'(kli_pkg::ch_value(n0, 3'(i)));
        end
      end
      S_DIV: begin
        tq   <= quo;
        ch   <= '0;
        ocnt <= '0;
      end
      S_MIX: begin
        res_status <= kli_pkg::ST_OK;
        if (!ch[3]) ch <= ch + 1'b1;
        if (mix_res_valid) begin
          res_val[ocnt] <= mix_result;
          ocnt          <= ocnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      out_x         <= res_val[0];
      out_y         <= res_val[1];
      out_z         <= res_val[2];
      out_red       <= res_val[3][7:0];
      out_green     <= res_val[4][7:0];
      out_blue      <= res_val[5][7:0];
      out_alpha     <= res_val[6][7:0];
      out_radius    <= res_val[7];
      segment_index <= res_seg;
    end
  end

endmodule
